// ===== sv/srhs_pkg.sv =====
// Shared types and constants for the sensor reading health supervisor.
// Holds word layouts, operation/outcome codes and register indexes.
// No dependencies.
package srhs_pkg;

    localparam int COUNTER_WIDTH_DEF = 32;
    localparam int TIME_WIDTH_DEF    = 48;

    // Width of the age arithmetic; all time math is done on this many bits.
    localparam int AGE_CALC_W = 64;

    localparam int IN_TDATA_W  = 112;
    localparam int OUT_TDATA_W = 272;
    localparam int CNT_OUT_W   = 32;
    localparam int AGE_W       = 49;
    localparam int PUB_W       = 11;

    localparam int APB_ADDR_W  = 5;
    localparam int APB_DATA_W  = 32;

    localparam logic [7:0]  HUM_CTRL_MASK   = 8'h07;
    localparam logic [7:0]  MEAS_CTRL_MASK  = 8'hFC;
    localparam logic [7:0]  FILTER_CFG_MASK = 8'h1C;
    localparam logic signed [15:0] TEMP_LO  = -16'sd400;
    localparam logic signed [15:0] TEMP_HI  = 16'sd850;
    localparam logic signed [15:0] HUM_LO   = 16'sd0;
    localparam logic signed [15:0] HUM_HI   = 16'sd1000;
    localparam logic [9:0]  FAULT_MAX       = 10'd600;
    localparam logic [31:0] STALE_LIMIT_RST = 32'd30000000;
    localparam logic signed [PUB_W-1:0] PUB_INVALID = '1;

    typedef enum logic [1:0] {
        OP_MEASURE = 2'd0,
        OP_CLEAR   = 2'd1,
        OP_QUERY   = 2'd2,
        OP_RSVD    = 2'd3
    } opcode_t;

    typedef enum logic [2:0] {
        OUT_ACCEPTED     = 3'd0,
        OUT_TRANSPORT    = 3'd1,
        OUT_DATA         = 3'd2,
        OUT_BOUNDS       = 3'd3,
        OUT_RECONFIGURED = 3'd4,
        OUT_RECONF_FAIL  = 3'd5,
        OUT_CLEARED      = 3'd6,
        OUT_QUERY        = 3'd7
    } outcome_t;

    typedef enum logic [1:0] {
        HEALTH_NEVER = 2'd0,
        HEALTH_ALIVE = 2'd1,
        HEALTH_STALE = 2'd2
    } health_t;

    typedef enum logic [1:0] {
        FAULT_NONE   = 2'd0,
        FAULT_SILENT = 2'd1,
        FAULT_BOUNDS = 2'd2,
        FAULT_LOST   = 2'd3
    } fault_t;

    typedef enum logic [1:0] {
        RS_OK        = 2'd0,
        RS_TRANSPORT = 2'd1,
        RS_NOT_READY = 2'd2,
        RS_RSVD      = 2'd3
    } read_status_t;

    typedef enum logic [2:0] {
        REG_EXP_HUM_CTRL   = 3'd0,
        REG_EXP_MEAS_CTRL  = 3'd1,
        REG_EXP_FILTER_CFG = 3'd2,
        REG_STALE_LIMIT    = 3'd3,
        REG_FAULT_KIND     = 3'd4,
        REG_FAULT_CYCLES   = 3'd5,
        REG_NONE6          = 3'd6,
        REG_NONE7          = 3'd7
    } reg_idx_t;

    localparam int NUM_CNT   = 6;
    localparam int CNT_GOOD  = 0;
    localparam int CNT_RECOV = 1;
    localparam int CNT_TRANS = 2;
    localparam int CNT_BOUND = 3;
    localparam int CNT_DATA  = 4;
    localparam int CNT_RECON = 5;

    typedef struct packed {
        logic [3:0]         pad;
        logic signed [15:0] hum_tenths_in;
        logic signed [15:0] temp_tenths_in;
        logic [1:0]         read_status;
        logic               reapply_ok;
        logic [7:0]         filter_cfg_read;
        logic [7:0]         meas_ctrl_read;
        logic [7:0]         hum_ctrl_read;
        logic               regs_read_ok;
        logic [47:0]        now_us;
    } in_word_t;

    typedef struct packed {
        logic [5:0]              pad;
        logic                    config_ok;
        logic [CNT_OUT_W-1:0]    reconfigurations;
        logic [CNT_OUT_W-1:0]    data_errors;
        logic [CNT_OUT_W-1:0]    bound_errors;
        logic [CNT_OUT_W-1:0]    transport_errors;
        logic [CNT_OUT_W-1:0]    recoveries;
        logic [CNT_OUT_W-1:0]    good_reads;
        logic signed [AGE_W-1:0] age_us;
        logic [1:0]              health;
        logic signed [PUB_W-1:0] hum_tenths_out;
        logic signed [PUB_W-1:0] temp_tenths_out;
    } out_word_t;

endpackage

// ===== sv/sensor_reading_health_supervisor.sv =====
// Sensor reading health supervisor: top level, single pass per word.
// Depends on srhs_pkg.
//
//  channel   dir   handshake              contents
//  s_axis    in    s_tvalid / s_tready    tuser opcode, tdata one measurement word
//  m_axis    out   m_tvalid / m_tready    tuser outcome, tdata health report word
//  apb       in    psel/penable/pready    six config registers, 4-byte stride
//
// Each word passes through the input register, then the whole
// update (fault countdown, readback check, bounds, counters, age compare) is
// done in one pass into the output register. A word can enter every cycle;
// the two registers give full throughput while the sink keeps m_tready high.
// A stalled sink holds the result and the input register, then s_tready drops.
// rst_n is asynchronous and resets the control and state registers; the data registers are not reset.
module sensor_reading_health_supervisor #(
    parameter int COUNTER_WIDTH = srhs_pkg::COUNTER_WIDTH_DEF,
    parameter int TIME_WIDTH    = srhs_pkg::TIME_WIDTH_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // input stream
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // tuser: opcode[1:0]
    input  logic [1:0]                          s_tuser,
    // tdata: now_us[47:0], regs_read_ok[48], hum_ctrl_read[56:49],
    //        meas_ctrl_read[64:57], filter_cfg_read[72:65], reapply_ok[73],
    //        read_status[75:74], temp_tenths_in[91:76], hum_tenths_in[107:92]
    input  logic [srhs_pkg::IN_TDATA_W-1:0]     s_tdata,
    // output stream
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // tuser: outcome[2:0]
    output logic [2:0]                          m_tuser,
    // tdata: temp_tenths_out[10:0], hum_tenths_out[21:11], health[23:22],
    //        age_us[72:24], good_reads[104:73], recoveries[136:105],
    //        transport_errors[168:137], bound_errors[200:169],
    //        data_errors[232:201], reconfigurations[264:233], config_ok[265]
    output logic [srhs_pkg::OUT_TDATA_W-1:0]    m_tdata,
    // configuration port
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [srhs_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [srhs_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [srhs_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                pready
);

    localparam int AW = srhs_pkg::AGE_CALC_W;

    // ---------------- configuration registers ----------------
    logic [7:0]  exp_hum_ctrl_reg;
    logic [7:0]  exp_meas_ctrl_reg;
    logic [7:0]  exp_filter_cfg_reg;
    logic [31:0] stale_limit_reg;
    logic [1:0]  fault_kind_reg;
    logic [9:0]  fault_cycles_reg;

    logic              cfg_wr;
    srhs_pkg::reg_idx_t cfg_idx;
    logic              fc_ok;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = srhs_pkg::reg_idx_t'(paddr[4:2]);
    // fault_cycles writes whose low ten bits exceed the limit are dropped entirely
    assign fc_ok   = (pwdata[9:0] <= srhs_pkg::FAULT_MAX);

    always_comb
    begin
        unique case (cfg_idx)
            srhs_pkg::REG_EXP_HUM_CTRL:   prdata = {24'd0, exp_hum_ctrl_reg};
            srhs_pkg::REG_EXP_MEAS_CTRL:  prdata = {24'd0, exp_meas_ctrl_reg};
            srhs_pkg::REG_EXP_FILTER_CFG: prdata = {24'd0, exp_filter_cfg_reg};
            srhs_pkg::REG_STALE_LIMIT:    prdata = stale_limit_reg;
            srhs_pkg::REG_FAULT_KIND:     prdata = {30'd0, fault_kind_reg};
            srhs_pkg::REG_FAULT_CYCLES:   prdata = {22'd0, fault_cycles_reg};
            default:                      prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            exp_hum_ctrl_reg   <= '0;
            exp_meas_ctrl_reg  <= '0;
            exp_filter_cfg_reg <= '0;
            stale_limit_reg    <= srhs_pkg::STALE_LIMIT_RST;
            fault_kind_reg     <= '0;
            fault_cycles_reg   <= '0;
        end
        else if (cfg_wr)
        begin
            unique case (cfg_idx)
                srhs_pkg::REG_EXP_HUM_CTRL:   exp_hum_ctrl_reg   <= pwdata[7:0];
                srhs_pkg::REG_EXP_MEAS_CTRL:  exp_meas_ctrl_reg  <= pwdata[7:0];
                srhs_pkg::REG_EXP_FILTER_CFG: exp_filter_cfg_reg <= pwdata[7:0];
                srhs_pkg::REG_STALE_LIMIT:    stale_limit_reg    <= pwdata;
                srhs_pkg::REG_FAULT_KIND:     fault_kind_reg     <= pwdata[1:0];
                srhs_pkg::REG_FAULT_CYCLES:
                begin
                    if (fc_ok)
                        fault_cycles_reg <= pwdata[9:0];
                end
                default: ;
            endcase
        end
    end

    // ---------------- input register ----------------
    logic               in_valid_reg;
    srhs_pkg::opcode_t  in_op_reg;
    srhs_pkg::in_word_t in_word_reg;
    logic               advance;
    logic               out_valid_reg;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_tready)
            in_valid_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_op_reg   <= srhs_pkg::opcode_t'(s_tuser);
            in_word_reg <= srhs_pkg::in_word_t'(s_tdata);
        end
    end

    // ---------------- supervisor state ----------------
    logic signed [srhs_pkg::PUB_W-1:0] pub_temp_reg, pub_temp_next;
    logic signed [srhs_pkg::PUB_W-1:0] pub_hum_reg, pub_hum_next;
    logic [TIME_WIDTH-1:0]             last_good_reg, last_good_next;
    logic                              time_valid_reg, time_valid_next;
    logic                              ever_read_reg, ever_read_next;
    logic                              degraded_reg, degraded_next;
    logic                              conforming_reg, conforming_next;
    srhs_pkg::fault_t                  fault_active_reg, fault_active_next;
    logic [9:0]                        fault_left_reg, fault_left_next;
    logic [COUNTER_WIDTH-1:0]          cnt_reg [srhs_pkg::NUM_CNT];
    logic [srhs_pkg::NUM_CNT-1:0]      cnt_inc;
    logic                              cnt_clr;
    srhs_pkg::outcome_t                outcome;

    // time stamp of this word, trimmed or widened to the time width
    logic [AW-1:0]         now_wide;
    logic [TIME_WIDTH-1:0] now_t;
    assign now_wide = AW'(in_word_reg.now_us);
    assign now_t    = now_wide[TIME_WIDTH-1:0];

    // readback check and bounds on the raw fields
    logic match;
    logic in_bounds;
    logic fault_run;
    logic [9:0] left_dec;

    assign match =
        ((in_word_reg.hum_ctrl_read & srhs_pkg::HUM_CTRL_MASK) ==
         (exp_hum_ctrl_reg & srhs_pkg::HUM_CTRL_MASK)) &&
        ((in_word_reg.meas_ctrl_read & srhs_pkg::MEAS_CTRL_MASK) ==
         (exp_meas_ctrl_reg & srhs_pkg::MEAS_CTRL_MASK)) &&
        ((in_word_reg.filter_cfg_read & srhs_pkg::FILTER_CFG_MASK) ==
         (exp_filter_cfg_reg & srhs_pkg::FILTER_CFG_MASK));

    assign in_bounds =
        (in_word_reg.temp_tenths_in >= srhs_pkg::TEMP_LO) &&
        (in_word_reg.temp_tenths_in <= srhs_pkg::TEMP_HI) &&
        (in_word_reg.hum_tenths_in  >= srhs_pkg::HUM_LO) &&
        (in_word_reg.hum_tenths_in  <= srhs_pkg::HUM_HI);

    assign fault_run = (in_op_reg == srhs_pkg::OP_MEASURE) && (fault_left_reg != '0);
    assign left_dec  = fault_left_reg - 10'd1;

    always_comb
    begin
        logic done;
        logic verdict;
        done              = 1'b0;
        verdict           = 1'b0;
        pub_temp_next     = pub_temp_reg;
        pub_hum_next      = pub_hum_reg;
        last_good_next    = last_good_reg;
        time_valid_next   = time_valid_reg;
        ever_read_next    = ever_read_reg;
        degraded_next     = degraded_reg;
        conforming_next   = conforming_reg;
        fault_active_next = fault_active_reg;
        fault_left_next   = fault_left_reg;
        cnt_inc           = '0;
        cnt_clr           = 1'b0;
        outcome           = srhs_pkg::OUT_QUERY;

        case (in_op_reg)
            srhs_pkg::OP_MEASURE:
            begin
                // fault countdown runs first; the kind in force is the old one
                if (fault_run)
                begin
                    fault_left_next = left_dec;
                    if (left_dec == '0)
                        fault_active_next = srhs_pkg::FAULT_NONE;
                    if (fault_active_reg == srhs_pkg::FAULT_SILENT)
                    begin
                        degraded_next                = 1'b1;
                        cnt_inc[srhs_pkg::CNT_TRANS] = 1'b1;
                        outcome                      = srhs_pkg::OUT_TRANSPORT;
                        done                         = 1'b1;
                    end
                    else if (fault_active_reg == srhs_pkg::FAULT_BOUNDS)
                    begin
                        degraded_next                = 1'b1;
                        cnt_inc[srhs_pkg::CNT_BOUND] = 1'b1;
                        outcome                      = srhs_pkg::OUT_BOUNDS;
                        done                         = 1'b1;
                    end
                end

                // readback check; a lost-config fault still pending forces a miss
                if (!done && in_word_reg.regs_read_ok)
                begin
                    verdict = match &&
                              !(fault_active_next == srhs_pkg::FAULT_LOST &&
                                fault_left_next != '0);
                    conforming_next = verdict;
                    if (!verdict)
                    begin
                        degraded_next = 1'b1;
                        done          = 1'b1;
                        if (!in_word_reg.reapply_ok)
                            outcome = srhs_pkg::OUT_RECONF_FAIL;
                        else
                        begin
                            cnt_inc[srhs_pkg::CNT_RECON] = 1'b1;
                            pub_temp_next   = srhs_pkg::PUB_INVALID;
                            pub_hum_next    = srhs_pkg::PUB_INVALID;
                            time_valid_next = 1'b0;
                            outcome         = srhs_pkg::OUT_RECONFIGURED;
                        end
                    end
                end

                if (!done && in_word_reg.read_status != srhs_pkg::RS_OK)
                begin
                    degraded_next = 1'b1;
                    done          = 1'b1;
                    if (in_word_reg.read_status == srhs_pkg::RS_TRANSPORT)
                    begin
                        cnt_inc[srhs_pkg::CNT_TRANS] = 1'b1;
                        outcome = srhs_pkg::OUT_TRANSPORT;
                    end
                    else
                    begin
                        // not ready and the spare code both count as data errors
                        cnt_inc[srhs_pkg::CNT_DATA] = 1'b1;
                        outcome = srhs_pkg::OUT_DATA;
                    end
                end

                if (!done && !in_bounds)
                begin
                    degraded_next                = 1'b1;
                    cnt_inc[srhs_pkg::CNT_BOUND] = 1'b1;
                    outcome                      = srhs_pkg::OUT_BOUNDS;
                    done                         = 1'b1;
                end

                if (!done)
                begin
                    cnt_inc[srhs_pkg::CNT_GOOD]  = 1'b1;
                    cnt_inc[srhs_pkg::CNT_RECOV] = degraded_reg && ever_read_reg;
                    degraded_next   = 1'b0;
                    ever_read_next  = 1'b1;
                    pub_temp_next   = in_word_reg.temp_tenths_in[srhs_pkg::PUB_W-1:0];
                    pub_hum_next    = in_word_reg.hum_tenths_in[srhs_pkg::PUB_W-1:0];
                    last_good_next  = now_t;
                    time_valid_next = 1'b1;
                    outcome         = srhs_pkg::OUT_ACCEPTED;
                end
            end
            srhs_pkg::OP_CLEAR:
            begin
                cnt_clr = 1'b1;
                outcome = srhs_pkg::OUT_CLEARED;
            end
            default:
                outcome = srhs_pkg::OUT_QUERY;
        endcase
    end

    // ---------------- report: age and health from the updated state ----------
    logic [AW-1:0]                  age_diff;
    logic                           time_fwd;
    logic signed [srhs_pkg::AGE_W-1:0] age_out;
    srhs_pkg::health_t              health;

    assign age_diff = AW'(now_t) - AW'(last_good_next);
    assign time_fwd = AW'(now_t) >= AW'(last_good_next);

    always_comb
    begin
        if (!time_valid_next)
        begin
            health  = ever_read_next ? srhs_pkg::HEALTH_STALE : srhs_pkg::HEALTH_NEVER;
            age_out = '1;
        end
        else if (time_fwd)
        begin
            health  = (age_diff < AW'(stale_limit_reg)) ? srhs_pkg::HEALTH_ALIVE
                                                        : srhs_pkg::HEALTH_STALE;
            age_out = age_diff[srhs_pkg::AGE_W-1:0];
        end
        else
        begin
            // clock went backwards: negative age, counted as alive
            health  = srhs_pkg::HEALTH_ALIVE;
            age_out = age_diff[srhs_pkg::AGE_W-1:0];
        end
    end

    // next counter values, and their report view at the fixed output width
    logic [COUNTER_WIDTH-1:0]      cnt_next [srhs_pkg::NUM_CNT];
    logic [srhs_pkg::CNT_OUT_W-1:0] cnt_view [srhs_pkg::NUM_CNT];

    always_comb
    begin
        for (int k = 0; k < srhs_pkg::NUM_CNT; k++)
        begin
            logic [AW-1:0] wide;
            if (cnt_clr)
                cnt_next[k] = '0;
            else
                cnt_next[k] = cnt_reg[k] + COUNTER_WIDTH'(cnt_inc[k]);
            wide        = AW'(cnt_next[k]);
            cnt_view[k] = wide[srhs_pkg::CNT_OUT_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pub_temp_reg     <= srhs_pkg::PUB_INVALID;
            pub_hum_reg      <= srhs_pkg::PUB_INVALID;
            last_good_reg    <= '0;
            time_valid_reg   <= 1'b0;
            ever_read_reg    <= 1'b0;
            degraded_reg     <= 1'b0;
            conforming_reg   <= 1'b1;
            fault_active_reg <= srhs_pkg::FAULT_NONE;
            fault_left_reg   <= '0;
            for (int k = 0; k < srhs_pkg::NUM_CNT; k++)
                cnt_reg[k] <= '0;
        end
        else
        begin
            if (advance)
            begin
                pub_temp_reg     <= pub_temp_next;
                pub_hum_reg      <= pub_hum_next;
                last_good_reg    <= last_good_next;
                time_valid_reg   <= time_valid_next;
                ever_read_reg    <= ever_read_next;
                degraded_reg     <= degraded_next;
                conforming_reg   <= conforming_next;
                fault_active_reg <= fault_active_next;
                fault_left_reg   <= fault_left_next;
                for (int k = 0; k < srhs_pkg::NUM_CNT; k++)
                    cnt_reg[k] <= cnt_next[k];
            end
            // fault_cycles write loads/cancels countdown (user: only while idle)
            if (cfg_wr && cfg_idx == srhs_pkg::REG_FAULT_CYCLES && fc_ok)
            begin
                if (fault_kind_reg == srhs_pkg::FAULT_NONE || pwdata[9:0] == '0)
                begin
                    fault_left_reg   <= '0;
                    fault_active_reg <= srhs_pkg::FAULT_NONE;
                end
                else
                begin
                    fault_left_reg   <= pwdata[9:0];
                    fault_active_reg <= srhs_pkg::fault_t'(fault_kind_reg);
                end
            end
        end
    end

    // ---------------- output register ----------------
    srhs_pkg::out_word_t out_word_reg;
    srhs_pkg::outcome_t  out_outcome_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= 1'b1;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_outcome_reg               <= outcome;
            out_word_reg.pad              <= '0;
            out_word_reg.config_ok        <= conforming_next;
            out_word_reg.reconfigurations <= cnt_view[srhs_pkg::CNT_RECON];
            out_word_reg.data_errors      <= cnt_view[srhs_pkg::CNT_DATA];
            out_word_reg.bound_errors     <= cnt_view[srhs_pkg::CNT_BOUND];
            out_word_reg.transport_errors <= cnt_view[srhs_pkg::CNT_TRANS];
            out_word_reg.recoveries       <= cnt_view[srhs_pkg::CNT_RECOV];
            out_word_reg.good_reads       <= cnt_view[srhs_pkg::CNT_GOOD];
            out_word_reg.age_us           <= age_out;
            out_word_reg.health           <= health;
            out_word_reg.hum_tenths_out   <= pub_hum_next;
            out_word_reg.temp_tenths_out  <= pub_temp_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_outcome_reg;
    assign m_tdata  = out_word_reg;

    // ---------------- assertions ----------------
    // an empty output register must never hold back the input side
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid_reg |-> s_tready)
        else $error("s_tready low with empty output register");

    // a pending countdown always has a kind, an expired one has none
    a_fault_consistent: assert property (@(posedge clk) disable iff (!rst_n)
        (fault_left_reg == '0) |-> (fault_active_reg == srhs_pkg::FAULT_NONE))
        else $error("fault kind active with no cycles left");

    // a valid timestamp only exists after a good reading
    a_time_implies_read: assert property (@(posedge clk) disable iff (!rst_n)
        time_valid_reg |-> ever_read_reg)
        else $error("time stamp valid before any good reading");

    // a time-stamped published temperature is inside the accepted range
    a_pub_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        time_valid_reg |-> (pub_temp_reg >= 11'sd0 - 11'sd400 &&
                            pub_temp_reg <= 11'sd850))
        else $error("published temperature out of range");

endmodule

// ===== tb/sv/tb_sensor_reading_health_supervisor.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for sensor_reading_health_supervisor.
// Depends on srhs_pkg and the block's RTL. Predicts each health report in SV,
// drives the input stream and the APB port, and checks every output word.
module tb_sensor_reading_health_supervisor;

    // Cycles with no word moving on either stream before the run is abandoned.
    // The longest legal quiet stretch is a drain plus six register writes.
    localparam int WATCHDOG_LIMIT = 400;
    // Pipeline depth is two words; give the tail some slack.
    localparam int TAIL_CYCLES    = 8;

    // Expected output word together with its outcome code (m_tuser).
    typedef struct packed {
        srhs_pkg::outcome_t  outcome;
        srhs_pkg::out_word_t word;
    } health_report_t;

    // ------------------------------------------------------------------
    // DUT connections; every input has a known value from time zero
    // ------------------------------------------------------------------
    logic                             clk      = 1'b0;
    logic                             rst_n    = 1'b0;
    logic                             s_tvalid = 1'b0;
    logic                             s_tready;
    logic [1:0]                       s_tuser  = '0;  // opcode[1:0]
    // in_word_t layout, now_us in the low bits
    logic [srhs_pkg::IN_TDATA_W-1:0]  s_tdata  = '0;
    logic                             m_tvalid;
    logic                             m_tready = 1'b0;
    logic [2:0]                       m_tuser;        // outcome[2:0]
    // out_word_t layout, temp_tenths_out lowest
    logic [srhs_pkg::OUT_TDATA_W-1:0] m_tdata;
    logic                             psel     = 1'b0;
    logic                             penable  = 1'b0;
    logic                             pwrite   = 1'b0;
    logic [srhs_pkg::APB_ADDR_W-1:0]  paddr    = '0;
    logic [srhs_pkg::APB_DATA_W-1:0]  pwdata   = '0;
    logic [srhs_pkg::APB_DATA_W-1:0]  prdata;
    logic                             pready;

    sensor_reading_health_supervisor u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tuser  (s_tuser),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tuser  (m_tuser),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // 4 ns period
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Predictor state: configuration copy plus supervisor state
    // ------------------------------------------------------------------
    logic [7:0]         cfg_hum_ctrl;
    logic [7:0]         cfg_meas_ctrl;
    logic [7:0]         cfg_filter_cfg;
    logic [31:0]        cfg_stale_limit;
    srhs_pkg::fault_t   cfg_fault_kind;
    logic [9:0]         cfg_fault_cycles;

    logic signed [15:0] pub_temp;
    logic signed [15:0] pub_hum;
    logic [47:0]        last_good_us;
    logic               stamp_valid;
    logic               seen_reading;
    logic               in_degraded;
    logic               readback_match;
    srhs_pkg::fault_t   fault_now;
    logic [9:0]         fault_remaining;
    logic [31:0]        event_count [srhs_pkg::NUM_CNT];

    health_report_t     pending_reports [$];
    logic [47:0]        clock_us;       // timestamp cursor for the stimulus
    bit                 idling;         // random gaps and stalls enabled
    int                 stall_left;
    int                 fail_count;
    int                 report_index;
    int                 quiet_cycles;

    initial
    begin
        cfg_hum_ctrl     = '0;
        cfg_meas_ctrl    = '0;
        cfg_filter_cfg   = '0;
        cfg_stale_limit  = srhs_pkg::STALE_LIMIT_RST;
        cfg_fault_kind   = srhs_pkg::FAULT_NONE;
        cfg_fault_cycles = '0;
        pub_temp         = -16'sd1;
        pub_hum          = -16'sd1;
        last_good_us     = '0;
        stamp_valid      = 1'b0;
        seen_reading     = 1'b0;
        in_degraded      = 1'b0;
        readback_match   = 1'b1;
        fault_now        = srhs_pkg::FAULT_NONE;
        fault_remaining  = '0;
        for (int k = 0; k < srhs_pkg::NUM_CNT; k++)
            event_count[k] = '0;
        clock_us     = 48'd1000;
        idling       = 1'b1;
        stall_left   = 0;
        fail_count   = 0;
        report_index = 0;
        quiet_cycles = 0;
    end

    // Register write as seen by the block.
    function automatic void apply_register(srhs_pkg::reg_idx_t idx, logic [31:0] value);
        case (idx)
            srhs_pkg::REG_EXP_HUM_CTRL:   cfg_hum_ctrl    = value[7:0];
            srhs_pkg::REG_EXP_MEAS_CTRL:  cfg_meas_ctrl   = value[7:0];
            srhs_pkg::REG_EXP_FILTER_CFG: cfg_filter_cfg  = value[7:0];
            srhs_pkg::REG_STALE_LIMIT:    cfg_stale_limit = value;
            srhs_pkg::REG_FAULT_KIND:     cfg_fault_kind  = srhs_pkg::fault_t'(value[1:0]);
            srhs_pkg::REG_FAULT_CYCLES:
            begin
                // out-of-range counts are dropped; zero or no kind cancels the fault
                if (value[9:0] <= srhs_pkg::FAULT_MAX)
                begin
                    cfg_fault_cycles = value[9:0];
                    if (cfg_fault_kind == srhs_pkg::FAULT_NONE || value[9:0] == 10'd0)
                    begin
                        fault_remaining = '0;
                        fault_now       = srhs_pkg::FAULT_NONE;
                    end
                    else
                    begin
                        fault_now       = cfg_fault_kind;
                        fault_remaining = value[9:0];
                    end
                end
            end
            default: ;
        endcase
    endfunction

    // Value a register read returns after the writes so far.
    function automatic logic [31:0] expected_readback(srhs_pkg::reg_idx_t idx);
        case (idx)
            srhs_pkg::REG_EXP_HUM_CTRL:   return {24'd0, cfg_hum_ctrl};
            srhs_pkg::REG_EXP_MEAS_CTRL:  return {24'd0, cfg_meas_ctrl};
            srhs_pkg::REG_EXP_FILTER_CFG: return {24'd0, cfg_filter_cfg};
            srhs_pkg::REG_STALE_LIMIT:    return cfg_stale_limit;
            srhs_pkg::REG_FAULT_KIND:     return {30'd0, cfg_fault_kind};
            srhs_pkg::REG_FAULT_CYCLES:   return {22'd0, cfg_fault_cycles};
            default:                      return '0;
        endcase
    endfunction

    // One measurement cycle; returns the outcome and updates the state.
    function automatic srhs_pkg::outcome_t measure_cycle(srhs_pkg::in_word_t w);
        srhs_pkg::fault_t   latched;
        logic signed [15:0] t;
        logic signed [15:0] h;
        logic               was_recovery;
        t = w.temp_tenths_in;
        h = w.hum_tenths_in;

        // injected fault countdown is decremented before it is acted on
        if (fault_remaining != 0)
        begin
            latched = fault_now;
            fault_remaining = fault_remaining - 10'd1;
            if (fault_remaining == 0)
                fault_now = srhs_pkg::FAULT_NONE;
            if (latched == srhs_pkg::FAULT_SILENT)
            begin
                in_degraded = 1'b1;
                event_count[srhs_pkg::CNT_TRANS]++;
                return srhs_pkg::OUT_TRANSPORT;
            end
            if (latched == srhs_pkg::FAULT_BOUNDS)
            begin
                in_degraded = 1'b1;
                event_count[srhs_pkg::CNT_BOUND]++;
                return srhs_pkg::OUT_BOUNDS;
            end
        end

        // readback check only when the bus read itself worked
        if (w.regs_read_ok)
        begin
            readback_match =
                ((w.hum_ctrl_read & srhs_pkg::HUM_CTRL_MASK) ==
                 (cfg_hum_ctrl & srhs_pkg::HUM_CTRL_MASK)) &&
                ((w.meas_ctrl_read & srhs_pkg::MEAS_CTRL_MASK) ==
                 (cfg_meas_ctrl & srhs_pkg::MEAS_CTRL_MASK)) &&
                ((w.filter_cfg_read & srhs_pkg::FILTER_CFG_MASK) ==
                 (cfg_filter_cfg & srhs_pkg::FILTER_CFG_MASK));
            if (fault_now == srhs_pkg::FAULT_LOST && fault_remaining != 0)
                readback_match = 1'b0;
            if (!readback_match)
            begin
                in_degraded = 1'b1;
                if (!w.reapply_ok)
                    return srhs_pkg::OUT_RECONF_FAIL;
                event_count[srhs_pkg::CNT_RECON]++;
                pub_temp    = -16'sd1;
                pub_hum     = -16'sd1;
                stamp_valid = 1'b0;
                return srhs_pkg::OUT_RECONFIGURED;
            end
        end

        if (w.read_status != srhs_pkg::RS_OK)
        begin
            in_degraded = 1'b1;
            if (w.read_status == srhs_pkg::RS_TRANSPORT)
            begin
                event_count[srhs_pkg::CNT_TRANS]++;
                return srhs_pkg::OUT_TRANSPORT;
            end
            // not ready and the reserved code both count as data errors
            event_count[srhs_pkg::CNT_DATA]++;
            return srhs_pkg::OUT_DATA;
        end

        if (t < srhs_pkg::TEMP_LO || t > srhs_pkg::TEMP_HI ||
            h < srhs_pkg::HUM_LO || h > srhs_pkg::HUM_HI)
        begin
            in_degraded = 1'b1;
            event_count[srhs_pkg::CNT_BOUND]++;
            return srhs_pkg::OUT_BOUNDS;
        end

        was_recovery = in_degraded && seen_reading;
        in_degraded  = 1'b0;
        seen_reading = 1'b1;
        pub_temp     = t;
        pub_hum      = h;
        last_good_us = w.now_us;
        stamp_valid  = 1'b1;
        event_count[srhs_pkg::CNT_GOOD]++;
        if (was_recovery)
            event_count[srhs_pkg::CNT_RECOV]++;
        return srhs_pkg::OUT_ACCEPTED;
    endfunction

    // Full health report for one accepted word.
    function automatic health_report_t supervise(srhs_pkg::opcode_t op,
                                                 srhs_pkg::in_word_t w);
        health_report_t r;
        logic [63:0]    age;
        r = '0;
        case (op)
            srhs_pkg::OP_MEASURE: r.outcome = measure_cycle(w);
            srhs_pkg::OP_CLEAR:
            begin
                for (int k = 0; k < srhs_pkg::NUM_CNT; k++)
                    event_count[k] = '0;
                r.outcome = srhs_pkg::OUT_CLEARED;
            end
            default:    r.outcome = srhs_pkg::OUT_QUERY;   // reserved opcode is a query
        endcase

        age = {16'd0, w.now_us} - {16'd0, last_good_us};
        if (!stamp_valid)
        begin
            r.word.health = seen_reading ? srhs_pkg::HEALTH_STALE : srhs_pkg::HEALTH_NEVER;
            age = '1;
        end
        else if (w.now_us >= last_good_us)
            r.word.health = (age < {32'd0, cfg_stale_limit}) ? srhs_pkg::HEALTH_ALIVE
                                                             : srhs_pkg::HEALTH_STALE;
        else
            r.word.health = srhs_pkg::HEALTH_ALIVE;   // time went backwards

        r.word.temp_tenths_out  = pub_temp[srhs_pkg::PUB_W-1:0];
        r.word.hum_tenths_out   = pub_hum[srhs_pkg::PUB_W-1:0];
        r.word.age_us           = age[srhs_pkg::AGE_W-1:0];
        r.word.good_reads       = event_count[srhs_pkg::CNT_GOOD];
        r.word.recoveries       = event_count[srhs_pkg::CNT_RECOV];
        r.word.transport_errors = event_count[srhs_pkg::CNT_TRANS];
        r.word.bound_errors     = event_count[srhs_pkg::CNT_BOUND];
        r.word.data_errors      = event_count[srhs_pkg::CNT_DATA];
        r.word.reconfigurations = event_count[srhs_pkg::CNT_RECON];
        r.word.config_ok        = readback_match;
        return r;
    endfunction

    task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
        if (want !== got)
        begin
            fail_count++;
            if (fail_count <= 10)
                $display("report %0d: %s expected %0h, got %0h", report_index, name, want, got);
        end
    endtask

    // ------------------------------------------------------------------
    // Bus-level tasks
    // ------------------------------------------------------------------

    // Push one word on the input stream; the prediction is made at the
    // accepting edge. tvalid is left high so back-to-back words stream.
    task automatic send_word(srhs_pkg::opcode_t op, srhs_pkg::in_word_t w);
        int gap;
        gap = (idling && $urandom_range(0, 4) == 0) ? $urandom_range(1, 3) : 0;
        w.pad = '0;
        @(negedge clk);
        if (gap != 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= w;
        do
            @(posedge clk);
        while (!s_tready);
        pending_reports.push_back(supervise(op, w));
    endtask

    // Stop sending and wait for every outstanding report.
    task automatic settle();
        @(negedge clk);
        s_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (pending_reports.size() != 0);
        repeat (2) @(posedge clk);
    endtask

    // APB write: setup, access, then release and read the register back.
    // Only called while idle.
    task automatic write_reg(srhs_pkg::reg_idx_t idx, logic [31:0] value);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        apply_register(idx, value);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        check_field("prdata", 64'(expected_readback(idx)), 64'(prdata));
    endtask

    // Build a measurement word. With match clear, one of the three readback
    // bytes gets at least one compared bit flipped.
    function automatic srhs_pkg::in_word_t build_word(logic [47:0] now, logic regs_ok,
                                                      logic match, logic reapply,
                                                      srhs_pkg::read_status_t st,
                                                      logic signed [15:0] t,
                                                      logic signed [15:0] h);
        srhs_pkg::in_word_t w;
        w = '0;
        w.now_us          = now;
        w.regs_read_ok    = regs_ok;
        w.hum_ctrl_read   = (cfg_hum_ctrl & srhs_pkg::HUM_CTRL_MASK) |
                            (8'($urandom) & ~srhs_pkg::HUM_CTRL_MASK);
        w.meas_ctrl_read  = (cfg_meas_ctrl & srhs_pkg::MEAS_CTRL_MASK) |
                            (8'($urandom) & ~srhs_pkg::MEAS_CTRL_MASK);
        w.filter_cfg_read = (cfg_filter_cfg & srhs_pkg::FILTER_CFG_MASK) |
                            (8'($urandom) & ~srhs_pkg::FILTER_CFG_MASK);
        if (!match)
        begin
            case ($urandom_range(0, 2))
                0:       w.hum_ctrl_read   ^= 8'($urandom_range(1, 7));
                1:       w.meas_ctrl_read  ^= 8'($urandom_range(1, 63) << 2);
                default: w.filter_cfg_read ^= 8'($urandom_range(1, 7) << 2);
            endcase
        end
        w.reapply_ok     = reapply;
        w.read_status    = st;
        w.temp_tenths_in = t;
        w.hum_tenths_in  = h;
        return w;
    endfunction

    // Measurement with a conforming readback; status and values as given.
    task automatic send_reading(logic [47:0] now, logic signed [15:0] t,
                                logic signed [15:0] h, srhs_pkg::read_status_t st);
        send_word(srhs_pkg::OP_MEASURE, build_word(now, 1'b1, 1'b1, 1'b1, st, t, h));
    endtask

    task automatic send_query(srhs_pkg::opcode_t op, logic [47:0] now);
        send_word(op, build_word(now, 1'b1, 1'b1, 1'b1, srhs_pkg::RS_OK, 16'sd0, 16'sd0));
    endtask

    // ------------------------------------------------------------------
    // Response side: random stall bursts, checking, watchdog
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (stall_left != 0)
        begin
            m_tready   <= 1'b0;
            stall_left <= stall_left - 1;
        end
        else
        begin
            m_tready <= 1'b1;
            if (idling && $urandom_range(0, 5) == 0)
                stall_left <= $urandom_range(1, 3);
        end
    end

    always @(posedge clk)
    begin : check_reports
        health_report_t      want;
        srhs_pkg::out_word_t got;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = m_tdata;
            if (pending_reports.size() == 0)
            begin
                fail_count++;
                if (fail_count <= 10)
                    $display("report %0d: word with nothing expected, tdata %0h",
                             report_index, m_tdata);
            end
            else
            begin
                want = pending_reports.pop_front();
                check_field("outcome", 64'(want.outcome), 64'(m_tuser));
                check_field("temp_tenths_out", 64'(want.word.temp_tenths_out),
                            64'(got.temp_tenths_out));
                check_field("hum_tenths_out", 64'(want.word.hum_tenths_out),
                            64'(got.hum_tenths_out));
                check_field("health", 64'(want.word.health), 64'(got.health));
                check_field("age_us", 64'(want.word.age_us), 64'(got.age_us));
                check_field("good_reads", 64'(want.word.good_reads),
                            64'(got.good_reads));
                check_field("recoveries", 64'(want.word.recoveries),
                            64'(got.recoveries));
                check_field("transport_errors", 64'(want.word.transport_errors),
                            64'(got.transport_errors));
                check_field("bound_errors", 64'(want.word.bound_errors),
                            64'(got.bound_errors));
                check_field("data_errors", 64'(want.word.data_errors),
                            64'(got.data_errors));
                check_field("reconfigurations", 64'(want.word.reconfigurations),
                            64'(got.reconfigurations));
                check_field("config_ok", 64'(want.word.config_ok), 64'(got.config_ok));
            end
            report_index++;
        end
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Before any reading: health never, age invalid, published values -1.
    task automatic test_power_up();
        send_query(srhs_pkg::OP_QUERY, 48'd5);
        send_query(srhs_pkg::OP_RSVD, 48'd6);
    endtask

    // Temperature and humidity at and just past their limits, and every
    // read status. The last reading follows errors, so it is a recovery.
    task automatic test_range_checks();
        settle();
        write_reg(srhs_pkg::REG_EXP_HUM_CTRL, 32'hA5);
        write_reg(srhs_pkg::REG_EXP_MEAS_CTRL, 32'h3C);
        write_reg(srhs_pkg::REG_EXP_FILTER_CFG, 32'hFF);
        send_reading(48'd100, -16'sd400, 16'sd0, srhs_pkg::RS_OK);
        send_reading(48'd200, 16'sd850, 16'sd1000, srhs_pkg::RS_OK);
        send_reading(48'd300, -16'sd401, 16'sd500, srhs_pkg::RS_OK);
        send_reading(48'd400, 16'sd851, 16'sd500, srhs_pkg::RS_OK);
        send_reading(48'd500, 16'sd0, -16'sd1, srhs_pkg::RS_OK);
        send_reading(48'd600, -16'sd32768, 16'sd32767, srhs_pkg::RS_OK);
        send_reading(48'd700, 16'sd10, 16'sd10, srhs_pkg::RS_TRANSPORT);
        send_reading(48'd800, 16'sd10, 16'sd10, srhs_pkg::RS_NOT_READY);
        send_reading(48'd900, 16'sd10, 16'sd10, srhs_pkg::RS_RSVD);
        send_reading(48'd1000, 16'sd215, 16'sd455, srhs_pkg::RS_OK);
    endtask

    // A failed bus read skips the comparison; a mismatch either reconfigures
    // (and invalidates the published value) or fails to.
    task automatic test_readback_check();
        send_word(srhs_pkg::OP_MEASURE, build_word(48'd1100, 1'b0, 1'b0, 1'b0,
                                                   srhs_pkg::RS_OK, 16'sd1, 16'sd2));
        send_word(srhs_pkg::OP_MEASURE, build_word(48'd1200, 1'b1, 1'b0, 1'b0,
                                                   srhs_pkg::RS_OK, 16'sd1, 16'sd2));
        send_word(srhs_pkg::OP_MEASURE, build_word(48'd1300, 1'b1, 1'b0, 1'b1,
                                                   srhs_pkg::RS_OK, 16'sd1, 16'sd2));
        send_reading(48'd1400, 16'sd3, 16'sd4, srhs_pkg::RS_OK);
    endtask

    // Age at the stale boundary, time running backwards, clear, and the
    // largest timestamp.
    task automatic test_reading_age();
        settle();
        write_reg(srhs_pkg::REG_STALE_LIMIT, 32'd1000);
        send_reading(48'd50000, 16'sd20, 16'sd30, srhs_pkg::RS_OK);
        send_query(srhs_pkg::OP_QUERY, 48'd50999);
        send_query(srhs_pkg::OP_QUERY, 48'd51000);
        send_query(srhs_pkg::OP_QUERY, 48'd49999);
        send_query(srhs_pkg::OP_CLEAR, 48'd52000);
        send_reading(48'hFFFF_FFFF_FFFF, 16'sd25, 16'sd35, srhs_pkg::RS_OK);
    endtask

    // Injected faults: silent, out of bounds, config lost, an ignored count,
    // and both ways of cancelling.
    task automatic test_fault_injection();
        settle();
        clock_us = 48'd100000;
        write_reg(srhs_pkg::REG_FAULT_KIND, 32'(srhs_pkg::FAULT_SILENT));
        write_reg(srhs_pkg::REG_FAULT_CYCLES, 32'd2);
        send_reading(clock_us + 48'd1, 16'sd5, 16'sd5, srhs_pkg::RS_OK);
        send_query(srhs_pkg::OP_QUERY, clock_us + 48'd2);   // queries do not count down
        send_reading(clock_us + 48'd3, 16'sd5, 16'sd5, srhs_pkg::RS_OK);
        send_reading(clock_us + 48'd4, 16'sd5, 16'sd5, srhs_pkg::RS_OK);
        settle();
        write_reg(srhs_pkg::REG_FAULT_KIND, 32'(srhs_pkg::FAULT_BOUNDS));
        write_reg(srhs_pkg::REG_FAULT_CYCLES, 32'd1);
        send_reading(clock_us + 48'd5, 16'sd5, 16'sd5, srhs_pkg::RS_OK);
        settle();
        write_reg(srhs_pkg::REG_FAULT_KIND, 32'(srhs_pkg::FAULT_LOST));
        write_reg(srhs_pkg::REG_FAULT_CYCLES, 32'd2);
        send_reading(clock_us + 48'd6, 16'sd6, 16'sd6, srhs_pkg::RS_OK);
        send_word(srhs_pkg::OP_MEASURE, build_word(clock_us + 48'd7, 1'b0, 1'b1, 1'b1,
                                                   srhs_pkg::RS_OK, 16'sd7, 16'sd7));
        settle();
        write_reg(srhs_pkg::REG_FAULT_CYCLES, 32'd700);     // above the maximum, dropped
        send_reading(clock_us + 48'd8, 16'sd8, 16'sd8, srhs_pkg::RS_OK);
        settle();
        write_reg(srhs_pkg::REG_FAULT_KIND, 32'(srhs_pkg::FAULT_SILENT));
        write_reg(srhs_pkg::REG_FAULT_CYCLES, 32'd3);
        write_reg(srhs_pkg::REG_FAULT_CYCLES, 32'd0);
        send_reading(clock_us + 48'd9, 16'sd9, 16'sd9, srhs_pkg::RS_OK);
        settle();
        write_reg(srhs_pkg::REG_FAULT_KIND, 32'(srhs_pkg::FAULT_NONE));
        write_reg(srhs_pkg::REG_FAULT_CYCLES, 32'd5);
        send_reading(clock_us + 48'd10, 16'sd10, 16'sd10, srhs_pkg::RS_OK);
        clock_us = clock_us + 48'd10;
    endtask

    // One random word, mostly well-formed measurement cycles.
    task automatic send_random_item();
        int                     pick;
        srhs_pkg::opcode_t      op;
        srhs_pkg::read_status_t st;
        logic signed [15:0]     t;
        logic signed [15:0]     h;
        pick = $urandom_range(0, 99);
        op = (pick < 86) ? srhs_pkg::OP_MEASURE : (pick < 90) ? srhs_pkg::OP_CLEAR :
             (pick < 96) ? srhs_pkg::OP_QUERY : srhs_pkg::OP_RSVD;

        pick = $urandom_range(0, 9);
        if (pick < 5)
            clock_us = clock_us + 48'($urandom_range(0, 2000));
        else if (pick < 7)
            clock_us = clock_us + 48'(cfg_stale_limit) +
                       48'($urandom_range(0, 4)) - 48'd2;
        else if (pick == 7)
            clock_us = clock_us + 48'($urandom);
        else if (pick == 8)
            clock_us = last_good_us - 48'($urandom_range(0, 3));
        else
            clock_us = {16'($urandom), 32'($urandom)};

        pick = $urandom_range(0, 99);
        st = (pick < 75) ? srhs_pkg::RS_OK : srhs_pkg::read_status_t'($urandom_range(1, 3));
        pick = $urandom_range(0, 9);
        if (pick < 8)
        begin
            t = 16'($urandom_range(0, 1250)) - 16'sd400;
            h = 16'($urandom_range(0, 1000));
        end
        else if (pick == 8)
        begin
            case ($urandom_range(0, 3))
                0:       t = -16'sd401;
                1:       t = -16'sd400;
                2:       t = 16'sd850;
                default: t = 16'sd851;
            endcase
            h = ($urandom_range(0, 1) != 0) ? 16'sd1000 + 16'($urandom_range(0, 1))
                                            : 16'sd0 - 16'($urandom_range(0, 1));
        end
        else
        begin
            t = 16'($urandom);
            h = 16'($urandom);
        end

        send_word(op, build_word(clock_us, $urandom_range(0, 9) != 0,
                                 $urandom_range(0, 99) < 85, $urandom_range(0, 3) != 0,
                                 st, t, h));
    endtask

    // Full register set for a phase of random traffic.
    task automatic program_phase(srhs_pkg::fault_t kind, logic [9:0] cycles,
                                 logic [31:0] stale);
        settle();
        write_reg(srhs_pkg::REG_EXP_HUM_CTRL, $urandom_range(0, 255));
        write_reg(srhs_pkg::REG_EXP_MEAS_CTRL, $urandom_range(0, 255));
        write_reg(srhs_pkg::REG_EXP_FILTER_CFG, $urandom_range(0, 255));
        write_reg(srhs_pkg::REG_STALE_LIMIT, stale);
        write_reg(srhs_pkg::REG_FAULT_KIND, 32'(kind));
        write_reg(srhs_pkg::REG_FAULT_CYCLES, 32'(cycles));
    endtask

    task automatic test_random_phases();
        program_phase(srhs_pkg::FAULT_NONE, 10'd0, $urandom_range(2000, 50000));
        repeat (210) send_random_item();
        program_phase(srhs_pkg::FAULT_SILENT, 10'($urandom_range(1, 20)), 32'd0);
        repeat (210) send_random_item();
        program_phase(srhs_pkg::FAULT_LOST, 10'($urandom_range(1, 40)), 32'hFFFF_FFFF);
        repeat (210) send_random_item();
        // longest fault, cut short by a cancelling write
        program_phase(srhs_pkg::FAULT_BOUNDS, srhs_pkg::FAULT_MAX, $urandom);
        repeat (60) send_random_item();
        settle();
        write_reg(srhs_pkg::REG_FAULT_CYCLES, 32'd0);
        repeat (150) send_random_item();
        // last stretch runs at full rate on both sides
        program_phase(srhs_pkg::fault_t'($urandom_range(0, 3)), 10'($urandom_range(0, 30)),
                      $urandom_range(500, 5000));
        idling = 1'b0;
        repeat (210) send_random_item();
    endtask

    initial
    begin
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;

        test_power_up();
        test_range_checks();
        test_readback_check();
        test_reading_age();
        test_fault_injection();
        test_random_phases();

        settle();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (pending_reports.size() != 0)
            fail_count++;
        if (fail_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
